[rtl/ui_rect_corner_layout_defines.svh]
// Assertion macros for the rectangle corner layout block
`ifndef UI_RECT_CORNER_LAYOUT_DEFINES_SVH
`define UI_RECT_CORNER_LAYOUT_DEFINES_SVH
`define URCL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define URCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

[rtl/urcl_pkg.sv]
// Types, constants and helper functions for the rectangle corner layout block
package urcl_pkg;
  localparam int CoordW = 24;
  localparam int TurnW = 16;
  localparam int AnchorW = 15;
  localparam int PivotW = 16;
  localparam logic [14:0] OneQ14 = 15'd16384;

  typedef enum logic [2:0] {
    REG_PARENT_LEFT   = 3'd0,
    REG_PARENT_TOP    = 3'd1,
    REG_PARENT_RIGHT  = 3'd2,
    REG_PARENT_BOTTOM = 3'd3,
    REG_PARENT_TURN   = 3'd4,
    REG_HAS_PARENT    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] anchor_min_x;
    logic [14:0] anchor_min_y;
    logic [14:0] anchor_max_x;
    logic [14:0] anchor_max_y;
    logic signed [23:0] near_x;
    logic signed [23:0] near_y;
    logic signed [23:0] far_x;
    logic signed [23:0] far_y;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic [15:0] local_turn;
  } req_t;

  typedef struct packed {
    logic [1:0] corner;
    logic signed [23:0] rot_x;
    logic signed [23:0] rot_y;
    logic signed [23:0] flat_x;
    logic signed [23:0] flat_y;
    logic signed [23:0] world_pos_x;
    logic signed [23:0] world_pos_y;
    logic signed [23:0] world_size_x;
    logic signed [23:0] world_size_y;
    logic [15:0] world_turn;
    logic last;
  } rsp_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7FFFFF;
    else if (v < -48'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic [14:0] clamp_anchor(input logic [14:0] a);
    return (a > OneQ14) ? OneQ14 : a;
  endfunction

  function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd8192;
    return t >>> 14;
  endfunction
endpackage

[rtl/ui_rect_corner_layout.sv]
// Top level of the rectangle corner layout block
// Usage:
//   Request channel: in_valid_i / in_stall_o carry one element request
//   (anchors, offsets or position and size, pivot, local angle).
//   Result channel: out_valid_o / out_stall_i give four corner results per
//   request, top-left, top-right, bottom-left, bottom-right; last marks the
//   fourth.
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i write the parent rectangle, parent angle and has_parent.
//   Write only while the block is idle.
// Timing:
//   Six register stages from request to first corner; the corner
//   sequencer at the end emits one corner a cycle while out_stall_i is
//   low; a new request enters only when the sequencer is empty or its last
//   corner is taken. Stages advance together and all hold while it is busy.
// Reset:
//   rst_ni clears all valid bits, the corner count and the parent registers to zero.
module ui_rect_corner_layout #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  urcl_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output urcl_pkg::rsp_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [23:0]    cfg_data_i
);
  import urcl_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_ENTRIES);

  logic signed [23:0] par_l_q, par_t_q, par_r_q, par_b_q;
  logic [15:0] par_turn_q;
  logic has_par_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_l_q <= '0; par_t_q <= '0; par_r_q <= '0; par_b_q <= '0;
      par_turn_q <= '0; has_par_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PARENT_LEFT:   par_l_q <= cfg_data_i;
        REG_PARENT_TOP:    par_t_q <= cfg_data_i;
        REG_PARENT_RIGHT:  par_r_q <= cfg_data_i;
        REG_PARENT_BOTTOM: par_b_q <= cfg_data_i;
        REG_PARENT_TURN:   par_turn_q <= cfg_data_i[15:0];
        REG_HAS_PARENT:    has_par_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] sine_quad(input logic [15:0] turn);
    logic [IdxW-1:0] idx;
    logic [15:0] ph;
    logic [14:0] z;
    idx = IdxW'(({16'd0, turn} * 32'(SINE_TABLE_ENTRIES)) >> 16);
    ph = 16'((64'(idx) * 64'd65536) / SINE_TABLE_ENTRIES);
    z = ph[14] ? 15'd16384 - 15'(ph[13:0]) : 15'(ph[13:0]);
    return {ph[15], z};
  endfunction

  function automatic logic [14:0] sine_sq(input logic [14:0] z);
    logic [29:0] p;
    p = 30'(z) * 30'(z);
    return 15'(p >> 14);
  endfunction

  function automatic logic [14:0] sine_mid(input logic [14:0] z2);
    logic [31:0] t;
    t = (32'd1160 * 32'(z2)) >> 14;
    t = (32'(z2) * (32'd10512 - t)) >> 14;
    return 15'(t);
  endfunction

  function automatic logic signed [15:0] sine_end(input logic [14:0] z,
                                                  input logic [14:0] u,
                                                  input logic neg);
    logic [31:0] t;
    t = (32'(z) * (32'd25736 - 32'(u))) >> 14;
    if (t > 32'd16384) t = 32'd16384;
    return neg ? -$signed(t[15:0]) : $signed(t[15:0]);
  endfunction

  // stage 1: anchors, anchor-point products, turn
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic adv;
  logic [1:0] cnt_q;
  logic s6_busy;

  logic fixed1_q, hp1_q;
  logic signed [23:0] near1x_q, near1y_q, far1x_q, far1y_q;
  logic signed [15:0] piv1x_q, piv1y_q;
  logic [15:0] turn1_q;
  logic signed [47:0] pmin_x_q, pmin_y_q, pmax_x_q, pmax_y_q;

  logic [14:0] amnx, amny, amxx, amxy;
  assign amnx = clamp_anchor(in_data_i.anchor_min_x);
  assign amny = clamp_anchor(in_data_i.anchor_min_y);
  assign amxx = clamp_anchor(in_data_i.anchor_max_x);
  assign amxy = clamp_anchor(in_data_i.anchor_max_y);

  logic signed [24:0] spx, spy;
  assign spx = 25'(par_r_q) - 25'(par_l_q);
  assign spy = 25'(par_b_q) - 25'(par_t_q);

  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hp1_q <= has_par_q;
      fixed1_q <= (amnx == amxx) && (amny == amxy);
      near1x_q <= in_data_i.near_x; near1y_q <= in_data_i.near_y;
      far1x_q <= in_data_i.far_x; far1y_q <= in_data_i.far_y;
      piv1x_q <= in_data_i.pivot_x; piv1y_q <= in_data_i.pivot_y;
      turn1_q <= has_par_q ? in_data_i.local_turn + par_turn_q : in_data_i.local_turn;
      pmin_x_q <= 48'(spx) * $signed({1'b0, amnx});
      pmin_y_q <= 48'(spy) * $signed({1'b0, amny});
      pmax_x_q <= 48'(spx) * $signed({1'b0, amxx});
      pmax_y_q <= 48'(spy) * $signed({1'b0, amxy});
    end
  end

  // stage 2: position and size, sine quadrant and square
  logic signed [23:0] pos2x_q, pos2y_q, sz2x_q, sz2y_q;
  logic signed [15:0] piv2x_q, piv2y_q;
  logic [15:0] turn2_q;
  logic [15:0] sinq2_q, cosq2_q;
  logic [14:0] sinsq2_q, cossq2_q;
  logic [15:0] sinq, cosq;
  logic signed [47:0] lox, loy, hix, hiy;
  assign lox = 48'(par_l_q) + rnd14(pmin_x_q) + 48'(near1x_q);
  assign loy = 48'(par_t_q) + rnd14(pmin_y_q) + 48'(near1y_q);
  assign hix = 48'(par_l_q) + rnd14(pmax_x_q) + 48'(far1x_q);
  assign hiy = 48'(par_t_q) + rnd14(pmax_y_q) + 48'(far1y_q);
  assign sinq = sine_quad(turn1_q);
  assign cosq = sine_quad(turn1_q + 16'd16384);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (adv) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      piv2x_q <= piv1x_q; piv2y_q <= piv1y_q; turn2_q <= turn1_q;
      sinq2_q <= sinq; cosq2_q <= cosq;
      sinsq2_q <= sine_sq(sinq[14:0]); cossq2_q <= sine_sq(cosq[14:0]);
      if (!hp1_q) begin
        pos2x_q <= near1x_q; pos2y_q <= near1y_q;
        sz2x_q <= far1x_q; sz2y_q <= far1y_q;
      end else if (fixed1_q) begin
        pos2x_q <= sat24(lox); pos2y_q <= sat24(loy);
        sz2x_q <= far1x_q; sz2y_q <= far1y_q;
      end else begin
        pos2x_q <= sat24(lox); pos2y_q <= sat24(loy);
        sz2x_q <= sat24(hix - lox); sz2y_q <= sat24(hiy - loy);
      end
    end
  end

  // stage 3: pivot products, sine polynomial middle term
  logic signed [23:0] pos3x_q, pos3y_q, sz3x_q, sz3y_q;
  logic [15:0] turn3_q;
  logic signed [47:0] pl3x_q, pl3y_q, ph3x_q, ph3y_q;
  logic [15:0] sinq3_q, cosq3_q;
  logic [14:0] sinu3_q, cosu3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (adv) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos3x_q <= pos2x_q; pos3y_q <= pos2y_q;
      sz3x_q <= sz2x_q; sz3y_q <= sz2y_q; turn3_q <= turn2_q;
      pl3x_q <= 48'(sz2x_q) * 48'(piv2x_q);
      pl3y_q <= 48'(sz2y_q) * 48'(piv2y_q);
      ph3x_q <= 48'(sz2x_q) * (48'sd16384 - 48'(piv2x_q));
      ph3y_q <= 48'(sz2y_q) * (48'sd16384 - 48'(piv2y_q));
      sinq3_q <= sinq2_q; cosq3_q <= cosq2_q;
      sinu3_q <= sine_mid(sinsq2_q); cosu3_q <= sine_mid(cossq2_q);
    end
  end

  // stage 4: flat corners, sine and cosine
  logic signed [23:0] pos4x_q, pos4y_q, sz4x_q, sz4y_q;
  logic signed [23:0] mnx4_q, mny4_q, mxx4_q, mxy4_q;
  logic [15:0] turn4_q;
  logic signed [15:0] sin4_q, cos4_q;
  logic signed [23:0] mnx, mny, mxx, mxy;
  assign mnx = sat24(48'(pos3x_q) - rnd14(pl3x_q));
  assign mny = sat24(48'(pos3y_q) - rnd14(pl3y_q));
  assign mxx = sat24(48'(pos3x_q) + rnd14(ph3x_q));
  assign mxy = sat24(48'(pos3y_q) + rnd14(ph3y_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (adv) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos4x_q <= pos3x_q; pos4y_q <= pos3y_q;
      sz4x_q <= sz3x_q; sz4y_q <= sz3y_q; turn4_q <= turn3_q;
      sin4_q <= sine_end(sinq3_q[14:0], sinu3_q, sinq3_q[15]);
      cos4_q <= sine_end(cosq3_q[14:0], cosu3_q, cosq3_q[15]);
      mnx4_q <= mnx; mny4_q <= mny; mxx4_q <= mxx; mxy4_q <= mxy;
    end
  end

  // stage 5: rotation products of all four corners
  logic signed [23:0] pos5x_q, pos5y_q, sz5x_q, sz5y_q;
  logic signed [23:0] mnx5_q, mny5_q, mxx5_q, mxy5_q;
  logic [15:0] turn5_q;
  logic signed [47:0] cdx_lo_q, cdx_hi_q, sdx_lo_q, sdx_hi_q;
  logic signed [47:0] cdy_lo_q, cdy_hi_q, sdy_lo_q, sdy_hi_q;
  logic signed [24:0] dxl, dxh, dyl, dyh;
  assign dxl = 25'(mnx4_q) - 25'(pos4x_q);
  assign dxh = 25'(mxx4_q) - 25'(pos4x_q);
  assign dyl = 25'(mny4_q) - 25'(pos4y_q);
  assign dyh = 25'(mxy4_q) - 25'(pos4y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (adv) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos5x_q <= pos4x_q; pos5y_q <= pos4y_q;
      sz5x_q <= sz4x_q; sz5y_q <= sz4y_q; turn5_q <= turn4_q;
      mnx5_q <= mnx4_q; mny5_q <= mny4_q; mxx5_q <= mxx4_q; mxy5_q <= mxy4_q;
      cdx_lo_q <= 48'(cos4_q) * 48'(dxl); cdx_hi_q <= 48'(cos4_q) * 48'(dxh);
      sdx_lo_q <= 48'(sin4_q) * 48'(dxl); sdx_hi_q <= 48'(sin4_q) * 48'(dxh);
      cdy_lo_q <= 48'(cos4_q) * 48'(dyl); cdy_hi_q <= 48'(cos4_q) * 48'(dyh);
      sdy_lo_q <= 48'(sin4_q) * 48'(dyl); sdy_hi_q <= 48'(sin4_q) * 48'(dyh);
    end
  end

  // stage 6: corner sequencer, one corner a cycle while out_stall_i is low
  logic signed [23:0] pos6x_q, pos6y_q, sz6x_q, sz6y_q;
  logic signed [23:0] mnx6_q, mny6_q, mxx6_q, mxy6_q;
  logic [15:0] turn6_q;
  logic signed [47:0] cdx_lo6_q, cdx_hi6_q, sdx_lo6_q, sdx_hi6_q;
  logic signed [47:0] cdy_lo6_q, cdy_hi6_q, sdy_lo6_q, sdy_hi6_q;
  logic s6_v_q;

  assign s6_busy = s6_v_q && !(cnt_q == 2'd3 && !out_stall_i);
  assign adv = !s6_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
      cnt_q <= '0;
    end else if (adv) begin
      s6_v_q <= s5_v_q;
      cnt_q <= '0;
    end else if (!out_stall_i) begin
      cnt_q <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos6x_q <= pos5x_q; pos6y_q <= pos5y_q;
      sz6x_q <= sz5x_q; sz6y_q <= sz5y_q; turn6_q <= turn5_q;
      mnx6_q <= mnx5_q; mny6_q <= mny5_q; mxx6_q <= mxx5_q; mxy6_q <= mxy5_q;
      cdx_lo6_q <= cdx_lo_q; cdx_hi6_q <= cdx_hi_q;
      sdx_lo6_q <= sdx_lo_q; sdx_hi6_q <= sdx_hi_q;
      cdy_lo6_q <= cdy_lo_q; cdy_hi6_q <= cdy_hi_q;
      sdy_lo6_q <= sdy_lo_q; sdy_hi6_q <= sdy_hi_q;
    end
  end

  logic signed [47:0] cdx, sdx, cdy, sdy;
  assign cdx = cnt_q[0] ? cdx_hi6_q : cdx_lo6_q;
  assign sdx = cnt_q[0] ? sdx_hi6_q : sdx_lo6_q;
  assign cdy = cnt_q[1] ? cdy_hi6_q : cdy_lo6_q;
  assign sdy = cnt_q[1] ? sdy_hi6_q : sdy_lo6_q;

  always_comb begin
    out_valid_o = s6_v_q;
    out_data_o.corner = cnt_q;
    out_data_o.flat_x = cnt_q[0] ? mxx6_q : mnx6_q;
    out_data_o.flat_y = cnt_q[1] ? mxy6_q : mny6_q;
    out_data_o.rot_x = sat24(48'(pos6x_q) + rnd14(cdx - sdy));
    out_data_o.rot_y = sat24(48'(pos6y_q) + rnd14(sdx + cdy));
    out_data_o.world_pos_x = pos6x_q;
    out_data_o.world_pos_y = pos6y_q;
    out_data_o.world_size_x = sz6x_q;
    out_data_o.world_size_y = sz6y_q;
    out_data_o.world_turn = turn6_q;
    out_data_o.last = (cnt_q == 2'd3);
  end
endmodule

[rtl/urcl_checker.sv]
// Port-level checker for the rectangle corner layout block, with its bind
`include "ui_rect_corner_layout_defines.svh"
module urcl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input urcl_pkg::rsp_t out_data_o
);
  import urcl_pkg::*;
  `URCL_ASSERT_IMPL(last_on_corner3, clk_i, rst_ni, out_valid_o,
    out_data_o.last == (out_data_o.corner == 2'd3))
  `URCL_ASSERT_NEXT(corner_steps, clk_i, rst_ni,
    out_valid_o && !out_stall_i && !out_data_o.last,
    out_valid_o && out_data_o.corner == $past(out_data_o.corner) + 2'd1)
  `URCL_ASSERT_NEXT(stall_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))
  `URCL_ASSERT_IMPL(busy_blocks_in, clk_i, rst_ni,
    out_valid_o && !out_data_o.last, in_stall_o)
endmodule

bind ui_rect_corner_layout urcl_checker u_urcl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_stall_o(in_stall_o), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .out_data_o(out_data_o)
);

[verif/ui_rect_corner_layout_checker.sv]
// Checker for the rectangle corner layout block: predicts corners and compares results
module ui_rect_corner_layout_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  urcl_pkg::req_t in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  urcl_pkg::rsp_t out_data_i,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [23:0]    cfg_data_i,
  output int             fail_count_o,
  output int             pending_o
);
  import urcl_pkg::*;

  localparam int TableEntries = 1024;

  logic signed [63:0] par_left, par_top, par_right, par_bottom;
  logic [15:0]        par_turn;
  logic               par_present;
  rsp_t               corner_queue[$];

  assign pending_o = corner_queue.size();

  function automatic logic signed [63:0] round14(input logic signed [63:0] v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [63:0] clip24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic logic [63:0] anchor_fix(input logic [14:0] a);
    return (a > 15'd16384) ? 64'd16384 : {49'd0, a};
  endfunction

  function automatic logic signed [63:0] sine_q14(input logic [15:0] turn);
    logic [63:0] idx, ph, f, z, z2, t;
    logic [1:0]  q;
    idx = ({48'd0, turn} * TableEntries) >> 16;
    ph  = ((idx * 65536) / TableEntries) & 64'hFFFF;
    q   = ph[15:14];
    f   = ph & 64'h3FFF;
    z   = q[0] ? 64'd16384 - f : f;
    z2  = (z * z) >> 14;
    t   = (64'd1160 * z2) >> 14;
    t   = (z2 * (64'd10512 - t)) >> 14;
    t   = (z * (64'd25736 - t)) >> 14;
    if (t > 64'd16384) t = 64'd16384;
    return q[1] ? -$signed(t) : $signed(t);
  endfunction

  function automatic logic signed [63:0] anchor_pt(input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi,
                                                   input logic [63:0] a);
    return lo + round14((hi - lo) * $signed(a));
  endfunction

  task automatic predict_corners(input req_t r);
    logic [63:0]        ax0, ay0, ax1, ay1;
    logic signed [63:0] nx, ny, fx, fy, px, py, posx, posy, szx, szy;
    logic signed [63:0] lox, loy, minx, miny, maxx, maxy, s, c, cx, cy, dx, dy;
    logic [15:0]        turn;
    rsp_t               e;
    ax0 = anchor_fix(r.anchor_min_x);
    ay0 = anchor_fix(r.anchor_min_y);
    ax1 = anchor_fix(r.anchor_max_x);
    ay1 = anchor_fix(r.anchor_max_y);
    nx = r.near_x; ny = r.near_y; fx = r.far_x; fy = r.far_y;
    px = r.pivot_x; py = r.pivot_y;
    if (!par_present) begin
      posx = nx; posy = ny; szx = fx; szy = fy;
      turn = r.local_turn;
    end else begin
      lox = anchor_pt(par_left, par_right, ax0) + nx;
      loy = anchor_pt(par_top, par_bottom, ay0) + ny;
      if (ax0 == ax1 && ay0 == ay1) begin
        szx = fx; szy = fy;
      end else begin
        szx = clip24(anchor_pt(par_left, par_right, ax1) + fx - lox);
        szy = clip24(anchor_pt(par_top, par_bottom, ay1) + fy - loy);
      end
      posx = clip24(lox); posy = clip24(loy);
      turn = r.local_turn + par_turn;
    end
    minx = clip24(posx - round14(szx * px));
    miny = clip24(posy - round14(szy * py));
    maxx = clip24(posx + round14(szx * (64'sd16384 - px)));
    maxy = clip24(posy + round14(szy * (64'sd16384 - py)));
    s = sine_q14(turn);
    c = sine_q14(turn + 16'd16384);
    for (int k = 0; k < 4; k++) begin
      cx = k[0] ? maxx : minx;
      cy = k[1] ? maxy : miny;
      dx = cx - posx; dy = cy - posy;
      e.corner       = k[1:0];
      e.rot_x        = 24'(clip24(posx + round14(c * dx - s * dy)));
      e.rot_y        = 24'(clip24(posy + round14(s * dx + c * dy)));
      e.flat_x       = 24'(cx);
      e.flat_y       = 24'(cy);
      e.world_pos_x  = 24'(posx);
      e.world_pos_y  = 24'(posy);
      e.world_size_x = 24'(szx);
      e.world_size_y = 24'(szy);
      e.world_turn   = turn;
      e.last         = (k == 3);
      corner_queue.push_back(e);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_c;
    if (!rst_ni) begin
      par_left <= 0; par_top <= 0; par_right <= 0; par_bottom <= 0;
      par_turn <= 0; par_present <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_PARENT_LEFT:   par_left <= $signed(cfg_data_i);
          REG_PARENT_TOP:    par_top <= $signed(cfg_data_i);
          REG_PARENT_RIGHT:  par_right <= $signed(cfg_data_i);
          REG_PARENT_BOTTOM: par_bottom <= $signed(cfg_data_i);
          REG_PARENT_TURN:   par_turn <= cfg_data_i[15:0];
          REG_HAS_PARENT:    par_present <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_corners(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (corner_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_c = corner_queue.pop_front();
          if (exp_c !== out_data_i) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, exp_c, out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

[verif/testbench.sv]
// Testbench top for the rectangle corner layout block: stimulus, idling phases and verdict
module testbench;
  import urcl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;
  int          fail_count, pending;
  int          cycle_count = 0;
  int          send_idle = 0, recv_stall = 0;
  int          request_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ui_rect_corner_layout u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  ui_rect_corner_layout_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic write_reg(input reg_idx_e idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic set_parent(input logic [23:0] l, input logic [23:0] t,
                            input logic [23:0] r, input logic [23:0] b,
                            input logic [15:0] turn, input logic present);
    drain_pipe();
    write_reg(REG_PARENT_LEFT, l);
    write_reg(REG_PARENT_TOP, t);
    write_reg(REG_PARENT_RIGHT, r);
    write_reg(REG_PARENT_BOTTOM, b);
    write_reg(REG_PARENT_TURN, {8'd0, turn});
    write_reg(REG_HAS_PARENT, {23'd0, present});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    request_count++;
  endtask

  function automatic logic [14:0] rand_anchor();
    case ($urandom_range(5))
      0: return 15'd0;
      1: return 15'd16384;
      2: return 15'($urandom_range(32767));
      default: return 15'($urandom_range(16384));
    endcase
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom);
      default: return 24'($signed($urandom_range(65535)) - 32768);
    endcase
  endfunction

  function automatic req_t rand_request();
    req_t r;
    r.anchor_min_x = rand_anchor();
    r.anchor_min_y = rand_anchor();
    if ($urandom_range(2) == 0) begin
      r.anchor_max_x = r.anchor_min_x;
      r.anchor_max_y = r.anchor_min_y;
    end else begin
      r.anchor_max_x = rand_anchor();
      r.anchor_max_y = rand_anchor();
    end
    r.near_x = rand_coord();
    r.near_y = rand_coord();
    r.far_x  = rand_coord();
    r.far_y  = rand_coord();
    r.pivot_x = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16384));
    r.pivot_y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(16384));
    r.local_turn = 16'($urandom);
    return r;
  endfunction

  initial begin
    req_t r;
    int   phase;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no parent, then fixed and stretch with extremes
    r = '0;
    r.far_x = 24'sd2560; r.far_y = 24'sd1280; r.pivot_x = 16'sd8192;
    r.pivot_y = 16'sd8192;
    send_request(r);
    r.local_turn = 16'd16384; send_request(r);
    r.near_x = 24'sh7FFFFF; r.near_y = 24'sh800000; r.far_x = 24'sh7FFFFF;
    r.far_y = 24'sh800000; r.local_turn = 16'hFFFF; send_request(r);
    r.pivot_x = 16'sh8000; r.pivot_y = 16'sh7FFF; send_request(r);
    set_parent(24'sd0, 24'sd0, 24'sd51200, 24'sd25600, 16'd8192, 1'b1);
    r = '0;
    r.anchor_min_x = 15'd8192; r.anchor_max_x = 15'd8192;
    r.anchor_min_y = 15'd8192; r.anchor_max_y = 15'd8192;
    r.far_x = 24'sd2560; r.far_y = 24'sd2560; send_request(r);
    r.anchor_min_x = 15'h7FFF; r.anchor_max_x = 15'd16384;
    r.anchor_min_y = 15'd20000; r.anchor_max_y = 15'd16384; send_request(r);
    r.anchor_min_x = 15'd0; r.anchor_max_x = 15'd16384;
    r.anchor_min_y = 15'd0; r.anchor_max_y = 15'd16384;
    r.near_x = 24'sd256; r.far_x = -24'sd256; send_request(r);
    r.far_x = -24'sd60000; r.far_y = 24'sh800000; send_request(r);
    r.near_x = 24'sh7FFFFF; r.near_y = 24'sh800000; r.local_turn = 16'hC000;
    send_request(r);
    set_parent(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'hFFFF, 1'b1);
    send_request(r);
    r.anchor_min_x = 15'd16384; r.anchor_max_x = 15'd0; send_request(r);
    r.anchor_min_y = 15'd5000; r.anchor_max_y = 15'd5000;
    r.anchor_min_x = 15'd5000; r.anchor_max_x = 15'd5000; send_request(r);

    for (int i = 0; i < 130; i++) begin
      phase = (i / 13) % 4;
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        default: begin send_idle = 38; recv_stall = 38; end
      endcase
      if (i % 26 == 25)
        set_parent(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   16'($urandom), 1'($urandom_range(3) != 0));
      send_request(rand_request());
    end

    set_parent(24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd0, 1'b0);
    send_request(rand_request());
    recv_stall = 0;
    drain_pipe();
    $display("Sent %0d requests across no-parent, fixed and stretch layouts,", request_count);
    $display("with parent extremes, rotations and four idling phases.");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
